@@ src/fees_pkg.sv @@
// Shared types and constants for the two-page flash record store.
// No dependencies; imported by the record memory and the top-level sequencer.
package fees_pkg;

	localparam int RECORDS_PER_PAGE = 128;
	localparam int MAX_IDS          = 4;
	localparam int ID_SLOTS         = 4;
	localparam int SLOT_W           = $clog2(RECORDS_PER_PAGE);
	localparam int ADDR_W           = SLOT_W + 1;
	localparam int K_W              = 3;

	localparam logic [31:0] ERASED_ID = 32'hFFFF_FFFF;

	// page states
	localparam logic [1:0] PG_CLEARED   = 2'd0;
	localparam logic [1:0] PG_RECEIVING = 2'd1;
	localparam logic [1:0] PG_ACTIVE    = 2'd2;
	localparam logic [1:0] PG_UNUSED    = 2'd3;

	// action codes
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_MOUNT = 2'd2;
	localparam logic [1:0] ACT_RSVD  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_ID_SLOT_0 = 3'd0;
	localparam logic [2:0] CFG_ID_SLOT_1 = 3'd1;
	localparam logic [2:0] CFG_ID_SLOT_2 = 3'd2;
	localparam logic [2:0] CFG_ID_SLOT_3 = 3'd3;
	localparam logic [2:0] CFG_IDS_USED  = 3'd4;

	typedef struct packed {
		logic [31:0] value;
		logic [31:0] id;
	} rec_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		rec_t              wr_rec;
		logic [1:0]        erase_mask;
	} store_req_t;

endpackage

@@ src/fees_store.sv @@
// Record memory of both flash pages with per-slot written bits.
// Depends on fees_pkg; an unwritten or erased slot reads as all ones.
module fees_store
	import fees_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output rec_t       rd_rec
);

	rec_t                             mem [2*RECORDS_PER_PAGE];
	logic [1:0][RECORDS_PER_PAGE-1:0] valid_q;
	rec_t                             rdata_q;
	logic                             rvld_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wr_rec;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	// written bits: set on write, drop a whole page on erase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rvld_q <= valid_q[req.addr[ADDR_W-1]][req.addr[SLOT_W-1:0]];
			end
			if (req.erase_mask[0]) begin
				valid_q[0] <= '0;
			end
			if (req.erase_mask[1]) begin
				valid_q[1] <= '0;
			end
			if (req.wr_en) begin
				valid_q[req.addr[ADDR_W-1]][req.addr[SLOT_W-1:0]] <= 1'b1;
			end
		end
	end

	assign rd_rec = rvld_q ? rdata_q : '1;

endmodule

@@ src/flash_eeprom_emulation_store_unit.sv @@
// Emulated EEPROM on two flash pages; one item in flight, one result per item.
// The record memory is single-ported and visited one slot at a time, with a read step and a
// check step per slot: a write scans up for a free slot, a read scans down for the newest
// record, and a page transfer copies the newest record of each id slot in use.
// The next item is taken in the cycle after the result is loaded; input stalls while busy.
// Reset: both pages cleared and every slot erased at once, id slots 0..3, two used.
module flash_eeprom_emulation_store_unit
	import fees_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] var_id,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [31:0] read_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_FREE_RD  = 7'b0000010,
		ST_FREE_CHK = 7'b0000100,
		ST_COPY_SEL = 7'b0001000,
		ST_FIND_RD  = 7'b0010000,
		ST_FIND_CHK = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [31:0]       id_q, val_q;
	logic              src_q, skip_q, copy_q;
	logic [SLOT_W-1:0] slot_q, dst_slot_q;
	logic [K_W-1:0]    k_q;
	logic              res_status_q;
	logic [31:0]       res_value_q;
	logic              out_valid_q, out_status_q;
	logic [31:0]       out_value_q;
	logic [1:0]        ps_q [2];
	logic [31:0]       id_slot_q [ID_SLOTS];
	logic [2:0]        used_q;

	store_req_t        req;
	rec_t              rd_rec;
	logic [K_W-1:0]    n_ids;
	logic              a0, a1, single_act, known_in, in_acc;
	logic [31:0]       find_id, cur_slot_id;
	logic              hit, is_free, slot_last, slot_first, k_done;
	logic [1:0]        mount_erase;

	fees_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_rec (rd_rec)
	);

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = out_value_q;

	// id slots in use, clipped to the supported count
	assign n_ids = (used_q > K_W'(MAX_IDS)) ? K_W'(MAX_IDS) : used_q;

	assign a0         = (ps_q[0] == PG_ACTIVE);
	assign a1         = (ps_q[1] == PG_ACTIVE);
	assign single_act = a0 ^ a1;

	always_comb begin
		known_in = 1'b0;
		for (int k = 0; k < ID_SLOTS; k++) begin
			if ((K_W'(k) < n_ids) && (id_slot_q[k] == var_id)) begin
				known_in = 1'b1;
			end
		end
	end

	assign cur_slot_id = id_slot_q[k_q[1:0]];
	assign find_id     = copy_q ? cur_slot_id : id_q;
	assign hit         = (rd_rec.id == find_id);
	assign is_free     = (rd_rec.id == ERASED_ID);
	assign slot_last   = (slot_q == SLOT_W'(RECORDS_PER_PAGE - 1));
	assign slot_first  = (slot_q == '0);
	assign k_done      = (k_q == n_ids);

	// mount wipes both pages when the state pair is ambiguous
	assign mount_erase = ((ps_q[0] == ps_q[1]) && (ps_q[0] != PG_UNUSED)) ? 2'b11 : 2'b00;

	// drive the record memory from the current step
	always_comb begin
		req            = '0;
		req.addr       = {src_q, slot_q};
		req.wr_rec     = '{value: val_q, id: id_q};
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (action == ACT_MOUNT)) begin
					req.erase_mask = mount_erase;
				end
			end
			ST_FREE_RD, ST_FIND_RD: begin
				req.rd_en = 1'b1;
			end
			ST_FREE_CHK: begin
				if (is_free) begin
					req.wr_en = 1'b1;
				end else if (slot_last) begin
					req.wr_en = 1'b1;
					req.addr  = {~src_q, SLOT_W'(0)};
				end
			end
			ST_COPY_SEL: begin
				if (k_done) begin
					req.erase_mask = src_q ? 2'b10 : 2'b01;
				end
			end
			ST_FIND_CHK: begin
				if (copy_q && hit) begin
					req.wr_en  = 1'b1;
					req.addr   = {~src_q, dst_slot_q};
					req.wr_rec = '{value: rd_rec.value, id: cur_slot_id};
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_slot_q[0] <= 32'd0;
			id_slot_q[1] <= 32'd1;
			id_slot_q[2] <= 32'd2;
			id_slot_q[3] <= 32'd3;
			used_q       <= 3'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ID_SLOT_0: id_slot_q[0] <= cfg_data;
				CFG_ID_SLOT_1: id_slot_q[1] <= cfg_data;
				CFG_ID_SLOT_2: id_slot_q[2] <= cfg_data;
				CFG_ID_SLOT_3: id_slot_q[3] <= cfg_data;
				CFG_IDS_USED:  used_q       <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// item payload; no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q  <= var_id;
			val_q <= write_value;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ps_q[0]      <= PG_CLEARED;
			ps_q[1]      <= PG_CLEARED;
			src_q        <= 1'b0;
			skip_q       <= 1'b0;
			copy_q       <= 1'b0;
			slot_q       <= '0;
			dst_slot_q   <= '0;
			k_q          <= '0;
			res_status_q <= 1'b0;
			res_value_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_value_q  <= '0;
		end else begin
			// drop the result once transferred
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_status_q <= 1'b1;
						res_value_q  <= '0;
						state_q      <= ST_DONE;
						src_q        <= a1;
						case (action)
							ACT_READ: begin
								if (single_act && (var_id != ERASED_ID)) begin
									copy_q  <= 1'b0;
									slot_q  <= SLOT_W'(RECORDS_PER_PAGE - 1);
									state_q <= ST_FIND_RD;
								end
							end
							ACT_WRITE: begin
								if (single_act && known_in && (var_id != ERASED_ID)) begin
									slot_q  <= '0;
									state_q <= ST_FREE_RD;
								end
							end
							ACT_MOUNT: begin
								res_status_q <= 1'b0;
								if (mount_erase[0]) begin
									ps_q[0] <= PG_ACTIVE;
									ps_q[1] <= PG_CLEARED;
								end else if (ps_q[0] == PG_RECEIVING && ps_q[1] == PG_CLEARED) begin
									ps_q[0] <= PG_ACTIVE;
								end else if (ps_q[0] == PG_CLEARED && ps_q[1] == PG_RECEIVING) begin
									ps_q[1] <= PG_ACTIVE;
								end else if ((ps_q[0] == PG_RECEIVING && a1) ||
									(a0 && ps_q[1] == PG_RECEIVING)) begin
									// copy newest values from the active page
									skip_q     <= 1'b0;
									dst_slot_q <= '0;
									k_q        <= '0;
									state_q    <= ST_COPY_SEL;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FREE_RD: begin
					state_q <= ST_FREE_CHK;
				end
				ST_FREE_CHK: begin
					if (is_free) begin
						res_status_q <= 1'b0;
						state_q      <= ST_DONE;
					end else if (slot_last) begin
						// page full: new record opens the other page
						ps_q[~src_q] <= PG_RECEIVING;
						skip_q       <= 1'b1;
						dst_slot_q   <= SLOT_W'(1);
						k_q          <= '0;
						state_q      <= ST_COPY_SEL;
					end else begin
						slot_q  <= slot_q + SLOT_W'(1);
						state_q <= ST_FREE_RD;
					end
				end
				ST_COPY_SEL: begin
					if (k_done) begin
						ps_q[src_q]  <= PG_CLEARED;
						ps_q[~src_q] <= PG_ACTIVE;
						res_status_q <= 1'b0;
						state_q      <= ST_DONE;
					end else if ((skip_q && (cur_slot_id == id_q)) ||
						(cur_slot_id == ERASED_ID)) begin
						k_q <= k_q + K_W'(1);
					end else begin
						copy_q  <= 1'b1;
						slot_q  <= SLOT_W'(RECORDS_PER_PAGE - 1);
						state_q <= ST_FIND_RD;
					end
				end
				ST_FIND_RD: begin
					state_q <= ST_FIND_CHK;
				end
				ST_FIND_CHK: begin
					if (hit) begin
						if (copy_q) begin
							dst_slot_q <= dst_slot_q + SLOT_W'(1);
							k_q        <= k_q + K_W'(1);
							state_q    <= ST_COPY_SEL;
						end else begin
							res_status_q <= 1'b0;
							res_value_q  <= rd_rec.value;
							state_q      <= ST_DONE;
						end
					end else if (slot_first) begin
						if (copy_q) begin
							k_q     <= k_q + K_W'(1);
							state_q <= ST_COPY_SEL;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						slot_q  <= slot_q - SLOT_W'(1);
						state_q <= ST_FIND_RD;
					end
				end
				ST_DONE: begin
					// hand the result over once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_value_q  <= res_value_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
